FILE: hw/rtl/opfr_pkg.sv
// ----------------------------------------------------------------------------
// opfr_pkg
// Shared types and constants of the optical preamble frame receiver: field
// widths, window length, reciprocal for the block average, register indexes.
// ----------------------------------------------------------------------------
package opfr_pkg;

   localparam int SAMPLE_BITS  = 10;
   localparam int DATA_BITS    = 4;
   localparam int PREAMBLE_LEN = 4;
   localparam int WINDOW       = 20;

   localparam int THR_BITS    = 10;
   localparam int MARGIN_BITS = 10;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 10;

   localparam int SUM_BITS   = $clog2(WINDOW * ((1 << SAMPLE_BITS) - 1) + 1);
   localparam int COUNT_BITS = $clog2(WINDOW + 1);
   localparam int POS_BITS   = $clog2((PREAMBLE_LEN > DATA_BITS) ? PREAMBLE_LEN : DATA_BITS);

   // floor(sum / WINDOW) as (sum * DIV_MUL) >> DIV_SHIFT, exact over the sum range
   localparam int DIV_SHIFT = SUM_BITS + 4;
   localparam int DIV_MUL   = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
   localparam int MUL_BITS  = DIV_SHIFT - $clog2(WINDOW) + 1;
   localparam int PROD_BITS = SUM_BITS + MUL_BITS;

   localparam logic [THR_BITS-1:0]    THR_RESET      = THR_BITS'(520);
   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET   = MARGIN_BITS'(5);
   localparam logic [PREAMBLE_LEN-1:0] PREAMBLE_RESET = PREAMBLE_LEN'(10);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [DATA_BITS-1:0]   data_type;
   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;
   typedef logic [CSR_DATA_BITS-1:0] csr_data_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INIT_THRESHOLD = 2'd0,
      CSR_NOISE_MARGIN   = 2'd1,
      CSR_PREAMBLE       = 2'd2
   } csr_index_type;

endpackage

FILE: hw/rtl/opfr_req_if.sv
// ----------------------------------------------------------------------------
// opfr_req_if
// Sample channel: valid/ready handshake carrying one ADC sample.
// ----------------------------------------------------------------------------
interface opfr_req_if;
   import opfr_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);

endinterface

FILE: hw/rtl/opfr_rsp_if.sv
// ----------------------------------------------------------------------------
// opfr_rsp_if
// Frame result channel: valid/ready handshake carrying one decoded frame.
// ----------------------------------------------------------------------------
interface opfr_rsp_if;
   import opfr_pkg::*;

   logic     valid;
   logic     ready;
   data_type data_bits;
   logic     frame_ok;
   data_type last_good;

   modport source (output valid, output data_bits, output frame_ok, output last_good,
                   input ready);
   modport sink   (input valid, input data_bits, input frame_ok, input last_good,
                   output ready);

endinterface

FILE: hw/rtl/optical_preamble_frame_receiver.sv
// ----------------------------------------------------------------------------
// optical_preamble_frame_receiver
// Adaptive threshold slicer with block averaging, preamble hunt, data capture
// and frame check.
// ----------------------------------------------------------------------------
// a frame result is shown from the result register; its last sample passes the sample register first
// throughput: one sample per cycle; the block average updates at acceptance,
//   slicing and framing run in the stage after the sample register
// a stalled result register holds both stages; samples still flow when no
//   result is pending
// reset: synchronous, active high; threshold 520, margin 5, preamble 4'b1010
// ----------------------------------------------------------------------------
module optical_preamble_frame_receiver (
   input  logic                 clock,
   input  logic                 reset,
   opfr_req_if.sink             req,
   opfr_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  opfr_pkg::csr_idx_type  csr_index,
   input  opfr_pkg::csr_data_type csr_wdata
);
   import opfr_pkg::*;

   // configuration
   logic [MARGIN_BITS-1:0]  margin_ff;
   logic [PREAMBLE_LEN-1:0] preamble_ff;

   // block average
   logic [THR_BITS-1:0]   thr_ff, thr_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [PROD_BITS-1:0]  quot_prod;

   // sample register
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff, s1_sample_in;

   // framing state
   logic                capture_ff, capture_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   data_type            bits_ff, bits_in;
   data_type            good_ff, good_in;

   // result register
   logic     rsp_valid_ff, rsp_valid_in;
   data_type rsp_data_ff, rsp_data_in;
   logic     rsp_ok_ff, rsp_ok_in;
   data_type rsp_good_ff, rsp_good_in;

   logic advance;
   logic accept;
   logic level;
   logic pair_ok;
   logic frame_ok;
   logic frame_done;
   data_type bits_new;
   logic [SAMPLE_BITS:0] diff;
   logic [SAMPLE_BITS:0] abs_diff;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign accept    = req.valid && req.ready;

   assign quot_prod = PROD_BITS'(sum_ff) * PROD_BITS'(DIV_MUL);

   // block average, updated in acceptance order
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      thr_in   = thr_ff;
      if (accept) begin
         if (count_ff < COUNT_BITS'(WINDOW)) begin
            sum_in   = sum_ff + SUM_BITS'(req.sample);
            count_in = count_ff + COUNT_BITS'(1);
         end else begin
            thr_in   = THR_BITS'(quot_prod >> DIV_SHIFT);
            sum_in   = '0;
            count_in = '0;
         end
      end
      // a threshold register write loads the slicing threshold at once
      if (csr_we && (csr_index == CSR_INIT_THRESHOLD)) begin
         thr_in = THR_BITS'(csr_wdata);
      end
   end

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_sample_in = s1_sample_ff;
      if (req.ready) begin
         s1_valid_in  = req.valid;
         s1_sample_in = req.sample;
      end
   end

   // slicer and frame check, threshold already updated by this sample
   assign level    = s1_sample_ff > SAMPLE_BITS'(thr_ff);
   assign bits_new = bits_ff | (DATA_BITS'(level) << pos_ff);
   assign diff     = {1'b0, s1_sample_ff} - (SAMPLE_BITS + 1)'(thr_ff);
   assign abs_diff = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;

   always_comb begin
      pair_ok = 1'b1;
      for (int i = 0; i + 1 < DATA_BITS; i += 2) begin
         if (bits_new[i] != bits_new[i+1]) begin
            pair_ok = 1'b0;
         end
      end
   end

   assign frame_ok = pair_ok && !(^bits_new) && !(^(~bits_new))
                     && (abs_diff >= (SAMPLE_BITS + 1)'(margin_ff));
   assign frame_done = capture_ff && (pos_ff == POS_BITS'(DATA_BITS - 1));

   always_comb begin
      capture_in   = capture_ff;
      pos_in       = pos_ff;
      bits_in      = bits_ff;
      good_in      = good_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_good_in  = rsp_good_ff;
      if (s1_valid_ff && advance) begin
         if (!capture_ff) begin
            if (level == preamble_ff[pos_ff]) begin
               if (pos_ff == POS_BITS'(PREAMBLE_LEN - 1)) begin
                  capture_in = 1'b1;
                  pos_in     = '0;
                  bits_in    = '0;
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
               end
            end else begin
               pos_in = '0;
            end
         end else if (!frame_done) begin
            bits_in = bits_new;
            pos_in  = pos_ff + POS_BITS'(1);
         end else begin
            if (frame_ok) begin
               good_in = bits_new;
            end
            rsp_valid_in = 1'b1;
            rsp_data_in  = bits_new;
            rsp_ok_in    = frame_ok;
            rsp_good_in  = frame_ok ? bits_new : good_ff;
            capture_in   = 1'b0;
            pos_in       = '0;
            bits_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         margin_ff    <= MARGIN_RESET;
         preamble_ff  <= PREAMBLE_RESET;
         thr_ff       <= THR_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         capture_ff   <= 1'b0;
         pos_ff       <= '0;
         bits_ff      <= '0;
         good_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         s1_valid_ff  <= s1_valid_in;
         capture_ff   <= capture_in;
         pos_ff       <= pos_in;
         bits_ff      <= bits_in;
         good_ff      <= good_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_NOISE_MARGIN:   margin_ff   <= MARGIN_BITS'(csr_wdata);
               CSR_PREAMBLE:       preamble_ff <= PREAMBLE_LEN'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_sample_ff <= s1_sample_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_good_ff  <= rsp_good_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.data_bits = rsp_data_ff;
   assign rsp.frame_ok  = rsp_ok_ff;
   assign rsp.last_good = rsp_good_ff;

endmodule
